### hdl/flst_pkg.sv
// flst_pkg: shared types and constants for the flat Lambert shade and
// vertex transform block.
// No dependencies.
package flst_pkg;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_ROW_X    = 3'd0,
		CFG_ROW_Y    = 3'd1,
		CFG_ROW_Z    = 3'd2,
		CFG_LIGHT    = 3'd3,
		CFG_COLOR    = 3'd4,
		CFG_COEF     = 3'd5
	} cfg_idx_t;

	localparam logic [63:0] ROW_X_RST = 64'h0000_0000_0000_0100;
	localparam logic [63:0] ROW_Y_RST = 64'h0000_0000_0100_0000;
	localparam logic [63:0] ROW_Z_RST = 64'h0000_0100_0000_0000;

	// square root: one result bit per stage, divider: one quotient bit per stage
	localparam int SQ_STEPS  = 25;
	localparam int DIV_STEPS = 17;

	// request data that rides along the shading stages
	typedef struct packed {
		logic               mode;
		logic signed [34:0] dot;
		logic        [15:0] vx;
		logic        [15:0] vy;
		logic        [15:0] vz;
	} side_t;

endpackage

### hdl/flat_lambert_shade_and_transform.sv
// flat_lambert_shade_and_transform: top level, face shading and vertex
// transform pipeline with square root and divider stages.
// Depends on flst_pkg.
//
//  channel   signals                                      handshake
//  input     mode pos_x/y/z normal_x/y/z                  in_valid / in_ready
//  output    kind red green blue out_x/y/z                out_valid / out_ready
//  config    cfg_index cfg_data                           cfg_we
//
// One request enters per cycle while the output is not stalled; the face path
// runs through the 25-stage square root and the 17-stage divider.
// Reset clears the valid bits and loads the register defaults.
// A stall at the output holds every stage; in_ready drops in the same cycle.
module flat_lambert_shade_and_transform (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] pos_z,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               kind,
	output logic        [15:0] red,
	output logic        [15:0] green,
	output logic        [15:0] blue,
	output logic signed [15:0] out_x,
	output logic signed [15:0] out_y,
	output logic signed [15:0] out_z,
	input  logic               cfg_we,
	input  logic         [2:0] cfg_index,
	input  logic        [63:0] cfg_data
);

	localparam int SQN = flst_pkg::SQ_STEPS;
	localparam int DVN = flst_pkg::DIV_STEPS;

	// configuration registers
	logic [63:0] mat_q [3];
	logic [47:0] light_q;
	logic [47:0] color_q;
	logic [63:0] coef_q;
	logic [31:0] ipkd_q;
	logic [31:0] amb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[0] <= flst_pkg::ROW_X_RST;
			mat_q[1] <= flst_pkg::ROW_Y_RST;
			mat_q[2] <= flst_pkg::ROW_Z_RST;
			light_q  <= '0;
			color_q  <= '0;
			coef_q   <= '0;
		end else if (cfg_we) begin
			case (flst_pkg::cfg_idx_t'(cfg_index))
				flst_pkg::CFG_ROW_X: mat_q[0] <= cfg_data;
				flst_pkg::CFG_ROW_Y: mat_q[1] <= cfg_data;
				flst_pkg::CFG_ROW_Z: mat_q[2] <= cfg_data;
				flst_pkg::CFG_LIGHT: light_q  <= cfg_data[47:0];
				flst_pkg::CFG_COLOR: color_q  <= cfg_data[47:0];
				flst_pkg::CFG_COEF:  coef_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// coefficient products, registered from the coefficient register
	always_ff @(posedge clk) begin
		ipkd_q <= coef_q[31:16] * coef_q[63:48];
		amb_q  <= coef_q[15:0] * coef_q[47:32];
	end

	// global advance
	logic en;
	logic v_s8;
	assign en       = !v_s8 || out_ready;
	assign in_ready = en;

	// stage 1: light vector, vertex products
	logic               v_s1;
	logic               mode_s1;
	logic signed [16:0] l_s1 [3];
	logic signed [15:0] n_s1 [3];
	logic signed [31:0] vp_s1 [3][3];
	logic signed [15:0] pin [3];
	logic signed [15:0] nin [3];

	assign pin[0] = pos_x;
	assign pin[1] = pos_y;
	assign pin[2] = pos_z;
	assign nin[0] = normal_x;
	assign nin[1] = normal_y;
	assign nin[2] = normal_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode;
			for (int i = 0; i < 3; i++) begin
				l_s1[i] <= 17'($signed(light_q[16*i +: 16])) - 17'(pin[i]);
				n_s1[i] <= nin[i];
				for (int j = 0; j < 3; j++)
					vp_s1[i][j] <= $signed(mat_q[i][16*j +: 16]) * pin[j];
			end
		end
	end

	// stage 2: squared length, dot product, vertex sum with rounding and saturation
	logic               v_s2;
	logic               mode_s2;
	logic        [33:0] sq_s2;
	logic signed [34:0] dot_s2;
	logic        [15:0] vo_s2 [3];
	logic        [33:0] sq_c;
	logic signed [34:0] dot_c;
	logic        [15:0] vo_c [3];
	logic signed [33:0] acc_c [3];
	logic signed [25:0] rnd_c [3];
	logic signed [33:0] lsq_c [3];
	logic signed [32:0] nl_c [3];

	always_comb begin
		sq_c  = '0;
		dot_c = '0;
		for (int i = 0; i < 3; i++) begin
			lsq_c[i] = l_s1[i] * l_s1[i];
			nl_c[i]  = n_s1[i] * l_s1[i];
			sq_c     = sq_c + 34'(lsq_c[i]);
			dot_c    = dot_c + 35'(nl_c[i]);
		end
		for (int r = 0; r < 3; r++) begin
			acc_c[r] = 34'(vp_s1[r][0]) + 34'(vp_s1[r][1]) + 34'(vp_s1[r][2])
				+ 34'($signed({mat_q[r][63:48], 8'h00})) + 34'sd128;
			rnd_c[r] = acc_c[r][33:8];
			if (rnd_c[r] > 26'sd32767)
				vo_c[r] = 16'h7FFF;
			else if (rnd_c[r] < -26'sd32768)
				vo_c[r] = 16'h8000;
			else
				vo_c[r] = rnd_c[r][15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2 <= mode_s1;
			sq_s2   <= sq_c;
			dot_s2  <= dot_c;
			vo_s2   <= vo_c;
		end
	end

	// stage group 3: restoring square root of sq * 2^16, one bit per stage
	logic                v_s3   [1:SQN];
	flst_pkg::side_t     sd_s3  [1:SQN];
	logic         [33:0] sq_s3  [1:SQN];
	logic         [26:0] rem_s3 [1:SQN];
	logic         [24:0] rt_s3  [1:SQN];

	for (genvar k = 0; k < SQN; k++) begin : g_sqrt
		localparam int P = SQN - 1 - k;
		logic            vi;
		flst_pkg::side_t sdi;
		logic     [33:0] sqi;
		logic     [26:0] remi;
		logic     [24:0] rti;
		logic      [1:0] pr;
		logic     [28:0] t;
		logic     [28:0] trial;
		logic            ge;

		if (k == 0) begin : g_first
			assign vi   = v_s2;
			assign sdi  = '{mode: mode_s2, dot: dot_s2,
				vx: vo_s2[0], vy: vo_s2[1], vz: vo_s2[2]};
			assign sqi  = sq_s2;
			assign remi = '0;
			assign rti  = '0;
		end else begin : g_rest
			assign vi   = v_s3[k];
			assign sdi  = sd_s3[k];
			assign sqi  = sq_s3[k];
			assign remi = rem_s3[k];
			assign rti  = rt_s3[k];
		end

		// the low sixteen radicand bits are zero
		if (P >= 8) begin : g_pair
			assign pr = sqi[2*P-15 -: 2];
		end else begin : g_zero
			assign pr = 2'b00;
		end

		assign t     = {remi, pr};
		assign trial = {2'b00, rti, 2'b01};
		assign ge    = t >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s3[k+1] <= 1'b0;
			else if (en) v_s3[k+1] <= vi;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd_s3[k+1]  <= sdi;
				sq_s3[k+1]  <= sqi;
				rem_s3[k+1] <= ge ? 27'(t - trial) : t[26:0];
				rt_s3[k+1]  <= {rti[23:0], ge};
			end
		end
	end

	// stage group 4: |dot| * 2^8 / len, one quotient bit per stage
	logic                v_s4   [1:DVN];
	flst_pkg::side_t     sd_s4  [1:DVN];
	logic         [24:0] len_s4 [1:DVN];
	logic         [42:0] rem_s4 [1:DVN];
	logic         [16:0] q_s4   [1:DVN];

	for (genvar j = 0; j < DVN; j++) begin : g_div
		localparam int I = DVN - 1 - j;
		logic            vi;
		flst_pkg::side_t sdi;
		logic     [24:0] lni;
		logic     [42:0] remi;
		logic     [16:0] qi;
		logic     [42:0] dv;
		logic            ge;

		if (j == 0) begin : g_first
			logic [34:0] mag;
			assign vi   = v_s3[SQN];
			assign sdi  = sd_s3[SQN];
			assign lni  = rt_s3[SQN];
			assign mag  = sdi.dot[34] ? 35'(-sdi.dot) : 35'(sdi.dot);
			assign remi = {mag, 8'h00};
			assign qi   = '0;
		end else begin : g_rest
			assign vi   = v_s4[j];
			assign sdi  = sd_s4[j];
			assign lni  = len_s4[j];
			assign remi = rem_s4[j];
			assign qi   = q_s4[j];
		end

		assign dv = {18'b0, lni} << I;
		assign ge = remi >= dv;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s4[j+1] <= 1'b0;
			else if (en) v_s4[j+1] <= vi;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sd_s4[j+1]  <= sdi;
				len_s4[j+1] <= lni;
				rem_s4[j+1] <= ge ? remi - dv : remi;
				q_s4[j+1]   <= {qi[15:0], ge};
			end
		end
	end

	// stage 5: signed cosine times Ip*kd; zero length gives zero cosine
	logic               v_s5;
	flst_pkg::side_t    sd_s5;
	logic signed [50:0] prod_s5;
	logic signed [17:0] cos_c;

	always_comb begin
		if (len_s4[DVN] == '0)
			cos_c = '0;
		else if (sd_s4[DVN].dot[34])
			cos_c = -$signed({1'b0, q_s4[DVN]});
		else
			cos_c = $signed({1'b0, q_s4[DVN]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4[DVN];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s5   <= sd_s4[DVN];
			prod_s5 <= $signed({1'b0, ipkd_q}) * cos_c;
		end
	end

	// stage 6: intensity = ambient + floor(diffuse / 2^14)
	logic               v_s6;
	flst_pkg::side_t    sd_s6;
	logic signed [37:0] inten_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (en) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s6    <= sd_s5;
			inten_s6 <= $signed({6'b0, amb_q}) + $signed({prod_s5[50], prod_s5[50:14]});
		end
	end

	// stage 7: colour times intensity
	logic            v_s7;
	flst_pkg::side_t sd_s7;
	logic            pos_s7;
	logic     [51:0] cp_s7 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (en) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s7  <= sd_s6;
			pos_s7 <= !inten_s6[37] && (inten_s6 != '0);
			for (int i = 0; i < 3; i++)
				cp_s7[i] <= color_q[16*i +: 16] * inten_s6[35:0];
		end
	end

	// stage 8: clamp and output register
	logic        kind_s8;
	logic [15:0] ch_s8 [3];
	logic [15:0] xyz_s8 [3];
	logic [15:0] ch_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (!pos_s7 || sd_s7.mode)
				ch_c[i] = '0;
			else if (cp_s7[i][51:40] != '0)
				ch_c[i] = 16'hFFFF;
			else
				ch_c[i] = cp_s7[i][39:24];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (en) v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s8   <= sd_s7.mode;
			ch_s8     <= ch_c;
			xyz_s8[0] <= sd_s7.mode ? sd_s7.vx : 16'h0000;
			xyz_s8[1] <= sd_s7.mode ? sd_s7.vy : 16'h0000;
			xyz_s8[2] <= sd_s7.mode ? sd_s7.vz : 16'h0000;
		end
	end

	assign out_valid = v_s8;
	assign kind      = kind_s8;
	assign red       = ch_s8[0];
	assign green     = ch_s8[1];
	assign blue      = ch_s8[2];
	assign out_x     = xyz_s8[0];
	assign out_y     = xyz_s8[1];
	assign out_z     = xyz_s8[2];

	// checks
	a_vertex_no_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind |-> red == '0 && green == '0 && blue == '0)
		else $error("vertex result carries colour");

	a_color_no_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !kind |-> out_x == '0 && out_y == '0 && out_z == '0)
		else $error("colour result carries vertex");

	a_zero_len_zero_dot: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4[DVN] && len_s4[DVN] == '0 |-> sd_s4[DVN].dot == '0)
		else $error("zero length with nonzero dot");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 && !out_ready |=> v_s8 && $stable(v_s7))
		else $error("pipeline moved during stall");

endmodule

### bench/testbench.sv
// testbench: self-checking bench for flat_lambert_shade_and_transform.
// Predicts face colors and transformed vertices per request and checks them.
// Depends on flst_pkg and the top-level RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 48;
	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT = 38;
	localparam int HOLD_CYCLES = 250;
	localparam logic [2:0] CFG_UNUSED = 3'd6;
	localparam logic MODE_FACE = 1'b0;
	localparam logic MODE_VERTEX = 1'b1;

	typedef struct packed {
		logic               mode;
		logic signed [15:0] px, py, pz;
		logic signed [15:0] nx, ny, nz;
	} request_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] r, g, b;
		logic [15:0] x, y, z;
	} shade_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic mode = 1'b0;
	logic signed [15:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic kind;
	logic [15:0] red, green, blue;
	logic signed [15:0] out_x, out_y, out_z;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	flat_lambert_shade_and_transform u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// bench copy of the register file
	logic [63:0] row_x = flst_pkg::ROW_X_RST, row_y = flst_pkg::ROW_Y_RST,
		row_z = flst_pkg::ROW_Z_RST;
	logic [63:0] light_pos = '0, surf_color = '0, light_coef = '0;

	request_t pending[$];
	shade_t expected_shades[$];
	int errors = 0;
	int faces_seen = 0, vertices_seen = 0;
	bit calm = 1'b0;
	bit hold_go = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int cycles = 0;

	function automatic longint s16(logic [63:0] v, int k);
		return longint'($signed(v[16*k +: 16]));
	endfunction

	function automatic longint u16(logic [63:0] v, int k);
		return longint'(v[16*k +: 16]);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bt;
		res = 0;
		bt = 64'd1 << 62;
		while (bt > v) bt >>= 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v -= res + bt;
				res = (res >> 1) + bt;
			end else begin
				res >>= 1;
			end
			bt >>= 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] xform_row(logic [63:0] row, longint x, longint y, longint z);
		longint acc, r;
		acc = s16(row, 0) * x + s16(row, 1) * y + s16(row, 2) * z + s16(row, 3) * 256;
		r = (acc + 128) >>> 8;
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	function automatic logic [15:0] lit_channel(longint c, longint inten);
		longint p;
		if (inten <= 0) return '0;
		p = (c * inten) >>> 24;
		if (p > 65535) return 16'hFFFF;
		return p[15:0];
	endfunction

	// expected color or vertex for one request under the current registers
	function automatic shade_t predict_shade(request_t q);
		shade_t s;
		longint lx, ly, lz, sq, dt, cosv, len, inten;
		s = '0;
		if (q.mode == MODE_VERTEX) begin
			s.kind = 1'b1;
			s.x = xform_row(row_x, q.px, q.py, q.pz);
			s.y = xform_row(row_y, q.px, q.py, q.pz);
			s.z = xform_row(row_z, q.px, q.py, q.pz);
		end else begin
			lx = s16(light_pos, 0) - q.px;
			ly = s16(light_pos, 1) - q.py;
			lz = s16(light_pos, 2) - q.pz;
			sq = lx * lx + ly * ly + lz * lz;
			dt = q.nx * lx + q.ny * ly + q.nz * lz;
			cosv = 0;
			// zero-length light vector leaves only the ambient term
			if (sq > 0) begin
				len = longint'(int_sqrt(longint'(sq) << 16));
				if (len > 0) cosv = (dt * 256) / len;
			end
			inten = u16(light_coef, 0) * u16(light_coef, 2)
				+ ((u16(light_coef, 1) * u16(light_coef, 3) * cosv) >>> 14);
			s.r = lit_channel(u16(surf_color, 0), inten);
			s.g = lit_channel(u16(surf_color, 1), inten);
			s.b = lit_channel(u16(surf_color, 2), inten);
		end
		return s;
	endfunction

	function automatic bit roll_idle();
		return !calm && ($urandom_range(99) < IDLE_PCT);
	endfunction

	// driver: offer queued requests, predict on each accepted one
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_shades.push_back(predict_shade({mode, pos_x, pos_y, pos_z,
					normal_x, normal_y, normal_z}));
			if (!in_valid || in_ready) begin
				if (pending.size() > 0 && !roll_idle()) begin
					request_t q;
					q = pending.pop_front();
					in_valid <= 1'b1;
					{mode, pos_x, pos_y, pos_z, normal_x, normal_y, normal_z} <= q;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h got %h", $realtime, name, want, got);
			errors++;
		end
	endtask

	// monitor: random backpressure, one long hold-off, in-order compare
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_shades.size() == 0) begin
					$display("%0t: unexpected result kind %b", $realtime, kind);
					errors++;
				end else begin
					shade_t e;
					e = expected_shades.pop_front();
					if (e.kind) vertices_seen++; else faces_seen++;
					check_field("kind", 16'(e.kind), 16'(kind));
					check_field("red", e.r, red);
					check_field("green", e.g, green);
					check_field("blue", e.b, blue);
					check_field("out_x", e.x, out_x);
					check_field("out_y", e.y, out_y);
					check_field("out_z", e.z, out_z);
				end
			end
			if (hold_go && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= !roll_idle();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [63:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			flst_pkg::CFG_ROW_X: row_x = v;
			flst_pkg::CFG_ROW_Y: row_y = v;
			flst_pkg::CFG_ROW_Z: row_z = v;
			flst_pkg::CFG_LIGHT: light_pos = {16'h0, v[47:0]};
			flst_pkg::CFG_COLOR: surf_color = {16'h0, v[47:0]};
			flst_pkg::CFG_COEF:  light_coef = v;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(logic [63:0] rx, logic [63:0] ry, logic [63:0] rz,
		logic [63:0] lp, logic [63:0] sc, logic [63:0] lc);
		write_reg(flst_pkg::CFG_ROW_X, rx);
		write_reg(flst_pkg::CFG_ROW_Y, ry);
		write_reg(flst_pkg::CFG_ROW_Z, rz);
		write_reg(flst_pkg::CFG_LIGHT, lp);
		write_reg(flst_pkg::CFG_COLOR, sc);
		write_reg(flst_pkg::CFG_COEF, lc);
	endtask

	task automatic drain();
		while (pending.size() > 0 || in_valid || expected_shades.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic request_t mk(logic m, int px, int py, int pz, int nx, int ny, int nz);
		request_t q;
		q = {m, 16'(px), 16'(py), 16'(pz), 16'(nx), 16'(ny), 16'(nz)};
		return q;
	endfunction

	function automatic logic [15:0] rnd_normal();
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	// random request: random mode, position near the light one time in four, else anywhere
	function automatic request_t rnd_request();
		request_t q;
		q.mode = 1'($urandom_range(1));
		q.px = 16'($urandom); q.py = 16'($urandom); q.pz = 16'($urandom);
		if ($urandom_range(3) == 0) begin
			q.px = light_pos[15:0] + 16'($signed($urandom_range(512)) - 256);
			q.py = light_pos[31:16] + 16'($signed($urandom_range(512)) - 256);
			q.pz = light_pos[47:32] + 16'($signed($urandom_range(512)) - 256);
		end
		q.nx = rnd_normal(); q.ny = rnd_normal(); q.nz = rnd_normal();
		return q;
	endfunction

	function automatic logic [63:0] rnd_coef();
		return {16'($urandom_range(8192)), 16'($urandom_range(8192)),
			16'($urandom_range(8192)), 16'($urandom_range(8192))};
	endfunction

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset registers: identity transform, black surface
		pending.push_back(mk(MODE_VERTEX, 16'sh0100, -256, 32767, 0, 0, 0));
		pending.push_back(mk(MODE_VERTEX, -32768, 32767, -32768, 0, 0, 0));
		pending.push_back(mk(MODE_FACE, 256, 0, 0, 16384, 0, 0));
		drain();

		// moderate setting plus a write to an index past the list
		write_all(64'h0080_0000_0000_0200, 64'hFF00_0000_0100_0000,
			64'h0000_0100_0000_0000, 64'h0000_0400_0000_0000,
			64'h8000_FFFF_4000_FFFF, 64'h1000_0800_1000_0400);
		write_reg(CFG_UNUSED, '1);
		pending.push_back(mk(MODE_FACE, 0, 0, 1024, 0, 0, 16384));   // zero-length L
		pending.push_back(mk(MODE_FACE, 0, 0, 0, 0, 0, 16384));      // facing light
		pending.push_back(mk(MODE_FACE, 0, 0, 0, 0, 0, -16384));     // facing away
		pending.push_back(mk(MODE_FACE, 0, 0, 0, 16384, 16384, 16384)); // non-unit
		pending.push_back(mk(MODE_FACE, 32767, 32767, 32767, -16384, -16384, -16384));
		pending.push_back(mk(MODE_FACE, -32768, -32768, -32768, 16384, 16384, 16384));
		pending.push_back(mk(MODE_FACE, 0, 0, 0, 0, 0, 0));
		pending.push_back(mk(MODE_VERTEX, 32767, 32767, 32767, 0, 0, 0));
		pending.push_back(mk(MODE_VERTEX, -32768, -32768, -32768, -1, -1, -1));
		pending.push_back(mk(MODE_VERTEX, 0, 0, 0, 0, 0, 0));
		drain();

		// all-ones extreme
		write_all('1, '1, '1, '1, '1, '1);
		pending.push_back(mk(MODE_FACE, 0, 0, 0, 16384, 0, 0));
		pending.push_back(mk(MODE_FACE, -1, -1, -1, 16384, 16384, 16384));
		pending.push_back(mk(MODE_VERTEX, -32768, 32767, -32768, 0, 0, 0));
		pending.push_back(mk(MODE_VERTEX, 32767, -32768, 32767, 0, 0, 0));
		repeat (30) pending.push_back(rnd_request());
		drain();

		// saturating matrix, max-positive light, zeros elsewhere
		write_all(64'h7FFF_7FFF_7FFF_7FFF, 64'h8000_8000_8000_8000, '0,
			64'h7FFF_7FFF_7FFF, '0, '0);
		pending.push_back(mk(MODE_VERTEX, 32767, 32767, 32767, 0, 0, 0));
		pending.push_back(mk(MODE_FACE, 32767, 32767, 32767, 16384, 16384, 16384));
		repeat (30) pending.push_back(rnd_request());
		drain();

		// random settings; one phase runs without idling, one with a long hold-off
		for (int ph = 0; ph < 5; ph++) begin
			write_all(rnd64(), rnd64(), rnd64(), rnd64(), rnd64(),
				(ph % 2) ? rnd_coef() : rnd64());
			calm = (ph == 1);
			hold_go = (ph == 3);
			repeat (95) pending.push_back(rnd_request());
			drain();
		end
		calm = 1'b0;

		$display("Checked %0d face colors and %0d vertex transforms over 9 register settings.",
			faces_seen, vertices_seen);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
